FILE: hdl/stkt_pkg.sv
// Package for the sorted time key table.
// Holds the sizes, the request and status codes shared by the interfaces and the RTL.
// No dependencies.
package stkt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PTR_W       = CNT_W + 1;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned DTOL_W      = 16;
  localparam int unsigned STOL_W      = 31;
  localparam int unsigned SUB_W       = KEY_WIDTH + 3;

  // Reset value of the duplicate tolerance register
  localparam logic [DTOL_W-1:0] DTOL_RESET = DTOL_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_SEARCH = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_READ   = 3'd3,
    KIND_LINEAR = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_e;

endpackage

FILE: hdl/stkt_if.sv
// Request and response channels of the sorted time key table.
// Valid/ready handshake with the payload alongside; depends on stkt_pkg.
interface stkt_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [stkt_pkg::KIND_W-1:0]          kind;
  logic signed [stkt_pkg::KEY_WIDTH-1:0] key;
  logic [stkt_pkg::IDX_W-1:0]           index;
  logic [stkt_pkg::STOL_W-1:0]          spacing_tolerance;

  modport source(output valid, kind, key, index, spacing_tolerance, input ready);
  modport sink(input valid, kind, key, index, spacing_tolerance, output ready);
endinterface

interface stkt_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [stkt_pkg::STATUS_W-1:0]        status;
  logic signed [stkt_pkg::POS_W-1:0]    position;
  logic signed [stkt_pkg::KEY_WIDTH-1:0] key_out;
  logic [stkt_pkg::CNT_W-1:0]           entry_count;
  logic                                 is_linear;

  modport source(output valid, status, position, key_out, entry_count, is_linear,
                 input ready);
  modport sink(input valid, status, position, key_out, entry_count, is_linear,
               output ready);
endinterface

FILE: hdl/sorted_time_key_table_top.sv
// Top level of the sorted time key table: sequencer, shared subtractor and key RAM.
// Depends on stkt_pkg, stkt_req_if, stkt_rsp_if and stkt_ram.
//
// The block holds up to 64 signed 16.16 time keys in ascending order in one
// RAM with a registered read port, and serves one request at a time; every
// request gives one response beat. All work goes through the RAM's one read
// port and one shared subtractor. A search bisects over at most 7 probes; an
// insert runs that search, then is rejected or moves the keys from the
// insertion point on up by one and writes the key; a delete moves the keys
// above the index down by one; a read fetches the key at the index; a
// linearity check stops at the first spacing out of tolerance. An index out
// of range, a linearity check on fewer than two keys and an unused kind go
// straight to the result. A finished result waits while an earlier response
// stays untaken. A new request is taken once the previous one has reached
// the response register, even if that response has not yet been taken. The
// key store has no reset; the entry count clears on reset and keys beyond it
// never reach a result.
module sorted_time_key_table_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  stkt_req_if.sink                    req_i,
  stkt_rsp_if.source                  rsp_o,
  input  logic                        dup_tol_we_i,
  input  logic [stkt_pkg::DTOL_W-1:0] dup_tol_wdata_i
);

  localparam int unsigned KW  = stkt_pkg::KEY_WIDTH;
  localparam int unsigned SW  = stkt_pkg::SUB_W;
  localparam int unsigned IW  = stkt_pkg::IDX_W;
  localparam int unsigned CW  = stkt_pkg::CNT_W;
  localparam int unsigned PW  = stkt_pkg::PTR_W;

  typedef logic signed [PW-1:0] ptr_t;
  typedef logic signed [SW-1:0] wide_t;
  typedef logic [CW-1:0]        cnt_t;

  typedef enum logic [16:0] {
    ST_IDLE = 17'b00000000000000001,
    ST_SRCH = 17'b00000000000000010,
    ST_SCMP = 17'b00000000000000100,
    ST_FEND = 17'b00000000000001000,
    ST_DUP  = 17'b00000000000010000,
    ST_SHRD = 17'b00000000000100000,
    ST_SHWR = 17'b00000000001000000,
    ST_PUT  = 17'b00000000010000000,
    ST_DRD  = 17'b00000000100000000,
    ST_DWR  = 17'b00000001000000000,
    ST_RDK  = 17'b00000010000000000,
    ST_RDV  = 17'b00000100000000000,
    ST_LRD  = 17'b00001000000000000,
    ST_LSUB = 17'b00010000000000000,
    ST_LDEV = 17'b00100000000000000,
    ST_LCHK = 17'b01000000000000000,
    ST_DONE = 17'b10000000000000000
  } state_e;

  function automatic wide_t sext(input logic [KW-1:0] v);
    sext = {{(SW - KW){v[KW-1]}}, v};
  endfunction

  // Control state
  state_e                       state_q, state_d;
  cnt_t                         count_q, count_d;
  logic [stkt_pkg::DTOL_W-1:0]  dtol_q;
  logic                         out_valid_q, out_valid_d;

  // Request and working registers
  logic [stkt_pkg::KIND_W-1:0]  kind_q, kind_d;
  logic [KW-1:0]                key_q, key_d;
  logic [IW-1:0]                idx_q, idx_d;
  logic [stkt_pkg::STOL_W-1:0]  stol_q, stol_d;
  ptr_t                         lo_q, lo_d, hi_q, hi_d, floor_q, floor_d;
  logic [IW-1:0]                mid_q, mid_d;
  cnt_t                         j_q, j_d;
  logic [KW-1:0]                prev_q, prev_d;
  wide_t                        delta_q, delta_d, acc_q, acc_d;

  // Result being built and result register
  logic [stkt_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic signed [stkt_pkg::POS_W-1:0] res_pos_q, res_pos_d;
  logic [KW-1:0]                res_key_q, res_key_d;
  logic                         res_lin_q, res_lin_d;
  logic [stkt_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic signed [stkt_pkg::POS_W-1:0] out_pos_q, out_pos_d;
  logic [KW-1:0]                out_key_q, out_key_d;
  cnt_t                         out_cnt_q, out_cnt_d;
  logic                         out_lin_q, out_lin_d;

  // RAM port
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr, ram_raddr;
  logic [KW-1:0]                ram_wdata, ram_rdata;

  // Shared subtractor
  wide_t                        sub_a, sub_b, sub_res;

  // Helpers
  logic                         req_beat;
  logic [PW-1:0]                mid_sum;
  ptr_t                         mid_ext, ins_pos;
  cnt_t                         ins_c, jm1, jp1, jp2;
  wide_t                        dtol_ext;
  logic [SW-1:0]                mag, stol_ext;

  assign req_beat  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  assign mid_sum   = lo_q + hi_q;
  assign mid_ext   = ptr_t'({{(PW - IW){1'b0}}, mid_q});
  assign ins_pos   = floor_q + ptr_t'(1);
  assign ins_c     = ins_pos[CW-1:0];
  assign jm1       = j_q - cnt_t'(1);
  assign jp1       = j_q + cnt_t'(1);
  assign jp2       = j_q + cnt_t'(2);
  assign dtol_ext  = wide_t'({{(SW - stkt_pkg::DTOL_W){1'b0}}, dtol_q});
  assign stol_ext  = {{(SW - stkt_pkg::STOL_W){1'b0}}, stol_q};
  assign mag       = acc_q[SW-1] ? (-acc_q) : acc_q;

  // Select operands of the shared subtractor
  always_comb begin
    sub_a = sext(key_q);
    sub_b = sext(ram_rdata);
    if (state_q == ST_LSUB) begin
      sub_a = sext(ram_rdata);
      sub_b = sext(prev_q);
    end else if (state_q == ST_LDEV) begin
      sub_a = acc_q;
      sub_b = delta_q;
    end
  end
  assign sub_res = sub_a - sub_b;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    kind_d       = kind_q;
    key_d        = key_q;
    idx_d        = idx_q;
    stol_d       = stol_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    floor_d      = floor_q;
    mid_d        = mid_q;
    j_d          = j_q;
    prev_d       = prev_q;
    delta_d      = delta_q;
    acc_d        = acc_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_key_d    = res_key_q;
    res_lin_d    = res_lin_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_key_d    = out_key_q;
    out_cnt_d    = out_cnt_q;
    out_lin_d    = out_lin_q;
    ram_we       = 1'b0;
    ram_waddr    = j_q[IW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = j_q[IW-1:0];

    // Drop the response once its beat is taken
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_beat) begin
          kind_d       = req_i.kind;
          key_d        = req_i.key;
          idx_d        = req_i.index;
          stol_d       = req_i.spacing_tolerance;
          lo_d         = ptr_t'(0);
          hi_d         = ptr_t'({1'b0, count_q}) - ptr_t'(1);
          j_d          = cnt_t'(0);
          res_status_d = stkt_pkg::STATUS_OK;
          res_pos_d    = '0;
          res_key_d    = '0;
          res_lin_d    = 1'b0;
          priority if (req_i.kind == stkt_pkg::KIND_SEARCH ||
                       req_i.kind == stkt_pkg::KIND_INSERT) begin
            state_d = ST_SRCH;
          end else if (req_i.kind == stkt_pkg::KIND_DELETE) begin
            if ({1'b0, req_i.index} >= count_q) begin
              res_status_d = stkt_pkg::STATUS_RANGE;
              state_d      = ST_DONE;
            end else if ({1'b0, req_i.index} + cnt_t'(1) < count_q) begin
              j_d     = {1'b0, req_i.index};
              state_d = ST_DRD;
            end else begin
              count_d = count_q - cnt_t'(1);
              state_d = ST_DONE;
            end
          end else if (req_i.kind == stkt_pkg::KIND_READ) begin
            if ({1'b0, req_i.index} >= count_q) begin
              res_status_d = stkt_pkg::STATUS_RANGE;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_RDK;
            end
          end else if (req_i.kind == stkt_pkg::KIND_LINEAR) begin
            if (count_q < cnt_t'(2)) begin
              res_lin_d = 1'b1;
              state_d   = ST_DONE;
            end else begin
              state_d = ST_LRD;
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      // Bisection step: issue the read of the middle key
      ST_SRCH: begin
        if (lo_q <= hi_q) begin
          mid_d     = mid_sum[IW:1];
          ram_raddr = mid_sum[IW:1];
          state_d   = ST_SCMP;
        end else begin
          floor_d = hi_q;
          state_d = ST_FEND;
        end
      end

      // Narrow the range on the sign of key minus middle key
      ST_SCMP: begin
        if (sub_res[SW-1]) begin
          hi_d    = mid_ext - ptr_t'(1);
          state_d = ST_SRCH;
        end else if (sub_res != '0) begin
          lo_d    = mid_ext + ptr_t'(1);
          state_d = ST_SRCH;
        end else begin
          floor_d = mid_ext;
          state_d = ST_FEND;
        end
      end

      // Search over: report, or fetch the floor key for an insert
      ST_FEND: begin
        ram_raddr = floor_q[IW-1:0];
        if (kind_q == stkt_pkg::KIND_SEARCH) begin
          res_pos_d = stkt_pkg::POS_W'(floor_q);
          state_d   = ST_DONE;
        end else begin
          res_pos_d = stkt_pkg::POS_W'(ins_pos);
          state_d   = ST_DUP;
        end
      end

      // Reject a near-duplicate or a full table, else open the gap
      ST_DUP: begin
        if (!floor_q[PW-1] && (sub_res < dtol_ext)) begin
          res_status_d = stkt_pkg::STATUS_DUPLICATE;
          state_d      = ST_DONE;
        end else if (count_q >= cnt_t'(stkt_pkg::TABLE_DEPTH)) begin
          res_status_d = stkt_pkg::STATUS_FULL;
          state_d      = ST_DONE;
        end else begin
          j_d     = count_q;
          state_d = (count_q > ins_c) ? ST_SHRD : ST_PUT;
        end
      end

      ST_SHRD: begin
        ram_raddr = jm1[IW-1:0];
        state_d   = ST_SHWR;
      end

      // Move one key up
      ST_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IW-1:0];
        ram_wdata = ram_rdata;
        j_d       = jm1;
        state_d   = (jm1 > ins_c) ? ST_SHRD : ST_PUT;
      end

      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = ins_c[IW-1:0];
        ram_wdata = key_q;
        count_d   = count_q + cnt_t'(1);
        state_d   = ST_DONE;
      end

      ST_DRD: begin
        ram_raddr = jp1[IW-1:0];
        state_d   = ST_DWR;
      end

      // Move one key down
      ST_DWR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IW-1:0];
        ram_wdata = ram_rdata;
        j_d       = jp1;
        if (jp2 < count_q) begin
          state_d = ST_DRD;
        end else begin
          count_d = count_q - cnt_t'(1);
          state_d = ST_DONE;
        end
      end

      ST_RDK: begin
        ram_raddr = idx_q;
        state_d   = ST_RDV;
      end

      ST_RDV: begin
        res_key_d = ram_rdata;
        state_d   = ST_DONE;
      end

      ST_LRD: begin
        ram_raddr = j_q[IW-1:0];
        state_d   = ST_LSUB;
      end

      // Take the spacing to the previous key
      ST_LSUB: begin
        prev_d = ram_rdata;
        if (j_q == cnt_t'(0)) begin
          j_d     = jp1;
          state_d = ST_LRD;
        end else if (j_q == cnt_t'(1)) begin
          delta_d = sub_res;
          if (jp1 >= count_q) begin
            res_lin_d = 1'b1;
            state_d   = ST_DONE;
          end else begin
            j_d     = jp1;
            state_d = ST_LRD;
          end
        end else begin
          acc_d   = sub_res;
          state_d = ST_LDEV;
        end
      end

      ST_LDEV: begin
        acc_d   = sub_res;
        state_d = ST_LCHK;
      end

      // Stop at the first spacing out of tolerance
      ST_LCHK: begin
        if (mag > stol_ext) begin
          res_lin_d = 1'b0;
          state_d   = ST_DONE;
        end else if (jp1 >= count_q) begin
          res_lin_d = 1'b1;
          state_d   = ST_DONE;
        end else begin
          j_d     = jp1;
          state_d = ST_LRD;
        end
      end

      // Hand the result to the response register once it is free
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = res_pos_q;
          out_key_d    = res_key_q;
          out_cnt_d    = count_q;
          out_lin_d    = res_lin_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dtol_q      <= stkt_pkg::DTOL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (dup_tol_we_i) begin
        dtol_q <= dup_tol_wdata_i;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    stol_q       <= stol_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    floor_q      <= floor_d;
    mid_q        <= mid_d;
    j_q          <= j_d;
    prev_q       <= prev_d;
    delta_q      <= delta_d;
    acc_q        <= acc_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_key_q    <= res_key_d;
    res_lin_q    <= res_lin_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_key_q    <= out_key_d;
    out_cnt_q    <= out_cnt_d;
    out_lin_q    <= out_lin_d;
  end

  // Key store
  stkt_ram #(
    .WIDTH(KW),
    .DEPTH(stkt_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Response beat
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.position    = out_pos_q;
  assign rsp_o.key_out     = out_key_q;
  assign rsp_o.entry_count = out_cnt_q;
  assign rsp_o.is_linear   = out_lin_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(stkt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + cnt_t'(1) || count_q == $past(count_q) - cnt_t'(1)))
    else $error("entry count moved by more than one");

  a_write_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ({1'b0, ram_waddr} <= count_q))
    else $error("key write beyond the used part of the table");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("response raised outside the result hand-over");
`endif

endmodule

FILE: hdl/stkt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module stkt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
